// ----- sv/aiops_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiops_pkg
// shared types and codes for the arcade i/o port block with its shift register
// ----------------------------------------------------------------------------
package aiops_pkg;

   // command codes
   localparam logic [1:0] CMD_PORT_READ  = 2'd0;
   localparam logic [1:0] CMD_PORT_WRITE = 2'd1;
   localparam logic [1:0] CMD_KEY_EVENT  = 2'd2;

   // port numbers
   localparam logic [7:0] PORT_ZERO   = 8'd0;
   localparam logic [7:0] PORT_INPUT1 = 8'd1;
   localparam logic [7:0] PORT_INPUT2 = 8'd2;
   localparam logic [7:0] PORT_SHIFT  = 8'd3;
   localparam logic [7:0] PORT_DATA   = 8'd4;
   localparam logic [7:0] PORT_SOUND1 = 8'd5;
   localparam logic [7:0] PORT_WDOG   = 8'd6;
   localparam logic [7:0] PORT_OFFSET = 8'd2;

   // key codes
   localparam logic [3:0] KC_FIRE       = 4'd0;
   localparam logic [3:0] KC_ALT_FIRE   = 4'd1;
   localparam logic [3:0] KC_MOVE_LEFT  = 4'd2;
   localparam logic [3:0] KC_MOVE_RIGHT = 4'd3;
   localparam logic [3:0] KC_COIN       = 4'd4;
   localparam logic [3:0] KC_START1     = 4'd5;
   localparam logic [3:0] KC_START2     = 4'd6;
   localparam logic [3:0] KC_QUIT       = 4'd7;

   // player key bit positions
   localparam int KEYS_W        = 6;
   localparam int KEYBIT_COIN   = 0;
   localparam int KEYBIT_START2 = 1;
   localparam int KEYBIT_START1 = 2;
   localparam int KEYBIT_SHOT   = 3;
   localparam int KEYBIT_LEFT   = 4;
   localparam int KEYBIT_RIGHT  = 5;

   // configuration register indexes
   localparam logic [1:0] CSR_SHIPS_SETTING  = 2'd0;
   localparam logic [1:0] CSR_BONUS_AT_1000  = 2'd1;
   localparam logic [1:0] CSR_COIN_INFO_DEMO = 2'd2;
   localparam logic [1:0] CSR_TILT_LEVEL     = 2'd3;

   // configuration reset values
   localparam logic [1:0] SHIPS_SETTING_RST  = 2'd3;
   localparam logic       BONUS_AT_1000_RST  = 1'b1;
   localparam logic       COIN_INFO_DEMO_RST = 1'b0;
   localparam logic       TILT_LEVEL_RST     = 1'b0;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] port_number;
      logic [7:0] write_byte;
      logic [3:0] key_code;
      logic       key_pressed;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       halt_request;
   } rsp_payload_type;

endpackage

// ----- sv/arcade_io_ports_with_shifter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_io_ports_with_shifter_unit
// cpu port reads and writes, key events and a 16-bit barrel shift register
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | req_payload_type
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_payload_type
//   csr_    | in        | csr_write_enable    | csr_index, csr_write_data
//
// one transaction per cycle while req_stall is low; each result appears in
// the output register in the cycle after acceptance. reset is synchronous
// and restores state and configuration. req_stall rises only while a result
// sits in the output register and rsp_stall is high.
// ----------------------------------------------------------------------------
module arcade_io_ports_with_shifter_unit
   import aiops_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [1:0]      csr_write_data
);

   logic [15:0]       shift_data_ff, shift_data_in;
   logic [2:0]        shift_offset_ff, shift_offset_in;
   logic [KEYS_W-1:0] player_keys_ff, player_keys_in;
   logic [1:0]        ships_setting_ff;
   logic              bonus_at_1000_ff;
   logic              coin_info_demo_ff;
   logic              tilt_level_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [7:0]        shifted;
   logic [3:0]        shift_amount;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign shift_amount = BYTE_BITS - {1'b0, shift_offset_ff};
   assign shifted      = 8'(shift_data_ff >> shift_amount);

   always_comb begin
      shift_data_in   = shift_data_ff;
      shift_offset_in = shift_offset_ff;
      player_keys_in  = player_keys_ff;
      rsp_data_in     = '0;
      unique case (req_data.command)
         CMD_PORT_READ: begin
            unique case (req_data.port_number)
               PORT_ZERO: rsp_data_in.read_data = '0;
               PORT_INPUT1: rsp_data_in.read_data = {1'b0, player_keys_ff[5:3], 1'b1,
                                                     player_keys_ff[2:0]};
               PORT_INPUT2: rsp_data_in.read_data = {coin_info_demo_ff, 3'b000,
                                                     bonus_at_1000_ff, tilt_level_ff,
                                                     ships_setting_ff};
               PORT_SHIFT: rsp_data_in.read_data = shifted;
               default: rsp_data_in.halt_request = 1'b1;
            endcase
         end
         CMD_PORT_WRITE: begin
            unique case (req_data.port_number) inside
               PORT_OFFSET: shift_offset_in = req_data.write_byte[2:0];
               PORT_DATA: shift_data_in = {req_data.write_byte, shift_data_ff[15:8]};
               PORT_SHIFT, PORT_SOUND1, PORT_WDOG: ;
               default: rsp_data_in.halt_request = 1'b1;
            endcase
         end
         CMD_KEY_EVENT: begin
            unique case (req_data.key_code) inside
               KC_FIRE, KC_ALT_FIRE: player_keys_in[KEYBIT_SHOT] = req_data.key_pressed;
               KC_MOVE_LEFT: player_keys_in[KEYBIT_LEFT] = req_data.key_pressed;
               KC_MOVE_RIGHT: player_keys_in[KEYBIT_RIGHT] = req_data.key_pressed;
               KC_COIN: player_keys_in[KEYBIT_COIN] = req_data.key_pressed;
               KC_START1: player_keys_in[KEYBIT_START1] = req_data.key_pressed;
               KC_START2: player_keys_in[KEYBIT_START2] = req_data.key_pressed;
               KC_QUIT: rsp_data_in.halt_request = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_data_ff     <= '0;
         shift_offset_ff   <= '0;
         player_keys_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            shift_data_ff   <= shift_data_in;
            shift_offset_ff <= shift_offset_in;
            player_keys_ff  <= player_keys_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ships_setting_ff  <= SHIPS_SETTING_RST;
         bonus_at_1000_ff  <= BONUS_AT_1000_RST;
         coin_info_demo_ff <= COIN_INFO_DEMO_RST;
         tilt_level_ff     <= TILT_LEVEL_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SHIPS_SETTING: ships_setting_ff <= csr_write_data;
            CSR_BONUS_AT_1000: bonus_at_1000_ff <= csr_write_data[0];
            CSR_COIN_INFO_DEMO: coin_info_demo_ff <= csr_write_data[0];
            CSR_TILT_LEVEL: tilt_level_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

endmodule
